FILE: sv/idc_pkg.sv
// Shared types, descriptor layout constants and CRC32C helpers for the descriptor checker.
`timescale 1ns / 1ps

package idc_pkg;

	localparam int DIGEST_BYTES = 32;
	localparam int IDX_W        = $clog2(DIGEST_BYTES);

	localparam logic [6:0] POS_HSIZE  = 7'd24;
	localparam logic [6:0] POS_DIGEST = 7'd32;
	localparam logic [6:0] POS_CHECK  = 7'd64;
	localparam logic [6:0] POS_TAIL   = 7'd68;
	localparam logic [6:0] POS_LAST   = 7'd127;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic status;
		logic bank;
	} verdict_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] header_byte(input logic [4:0] p);
		logic [7:0] v;
		v = 8'd0;
		unique case (p)
			5'd0:  v = 8'h56;
			5'd1:  v = 8'h46;
			5'd2:  v = 8'h49;
			5'd3:  v = 8'h4E;
			5'd4:  v = 8'h54;
			5'd5:  v = 8'h45;
			5'd6:  v = 8'h47;
			5'd8:  v = 8'd1;
			5'd12: v = 8'd128;
			5'd16: v = 8'd1;
			5'd20: v = 8'd32;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/integrity_descriptor_checker_top.sv
// Top level of the footer descriptor integrity checker.
`timescale 1ns / 1ps

// Takes a 128-byte footer descriptor one byte per cycle, runs CRC32C over it
// (bytes 64..67 counted as zero) and checks magic, version, size, algorithm,
// digest length, hashed size against size_value and the zero tail. After
// byte 127 it returns one invalid result, or 32 results with the stored digest
// bytes 32..63, at one result per cycle while pop keeps up. Input takes one byte per cycle; it
// holds off (full) at bytes 32..63 while both digest banks still await
// readout, and at byte 127 while the two-entry verdict queue is full.
// The user must write size_value only while the block is idle; the block does not enforce it.
module integrity_descriptor_checker_top import idc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       desc_byte,
	input  logic             frame_start,
	output logic             empty,
	input  logic             pop,
	output logic             status,
	output logic [7:0]       digest_byte,
	output logic [IDX_W-1:0] digest_index,
	output logic             last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [63:0]      size_value
);

	logic [63:0]    prot_size_q;
	release_t       rel;
	logic           vq_push;
	verdict_t       vq_din;
	logic           vq_full;
	logic           vq_pop;
	verdict_t       vq_head;
	logic           vq_empty;
	logic           ram_we;
	logic [IDX_W:0] ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [IDX_W:0] ram_raddr;
	logic [7:0]     ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prot_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			prot_size_q <= size_value;
		end
	end

	idc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.desc_byte  (desc_byte),
		.frame_start(frame_start),
		.size_cfg   (prot_size_q),
		.rel        (rel),
		.vq_full    (vq_full),
		.vq_push    (vq_push),
		.vq_din     (vq_din),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	idc_fifo #(
		.ENTRY_T(verdict_t),
		.DEPTH  (2)
	) u_verdict_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (vq_push),
		.din   (vq_din),
		.full  (vq_full),
		.pop   (vq_pop),
		.dout  (vq_head),
		.empty (vq_empty)
	);

	idc_ram #(
		.WIDTH(8),
		.DEPTH(2 * DIGEST_BYTES)
	) u_digest_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	idc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.vq_empty    (vq_empty),
		.vq_head     (vq_head),
		.vq_pop      (vq_pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.rel         (rel),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.digest_byte (digest_byte),
		.digest_index(digest_index),
		.last        (last)
	);

endmodule

FILE: sv/idc_fifo.sv
// Small register FIFO with occupancy count.
`timescale 1ns / 1ps

module idc_fifo #(
	parameter type ENTRY_T = logic,
	parameter int DEPTH = 2,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ENTRY_T           din,
	output logic             full,
	input  logic             pop,
	output ENTRY_T           dout,
	output logic             empty
);

	ENTRY_T           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

FILE: sv/idc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module idc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/idc_front.sv
// Front end: byte intake, CRC32C, field checks, digest capture and verdict issue.
`timescale 1ns / 1ps

module idc_front import idc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       desc_byte,
	input  logic             frame_start,
	input  logic [63:0]      size_cfg,
	input  release_t         rel,
	input  logic             vq_full,
	output logic             vq_push,
	output verdict_t         vq_din,
	output logic             ram_we,
	output logic [IDX_W:0]   ram_waddr,
	output logic [7:0]       ram_wdata
);

	logic [6:0]  pos_q;
	logic [31:0] crc_q;
	logic [31:0] chk_q;
	logic        mism_q;
	logic        bank_q;
	logic [1:0]  busy_q;

	logic        accept;
	logic [6:0]  p;
	logic [6:0]  p_off;
	logic        in_hsize;
	logic        in_header;
	logic        in_digest;
	logic        in_check;
	logic        in_tail;
	logic [31:0] crc_base;
	logic [31:0] crc_next;
	logic [31:0] chk_base;
	logic [31:0] chk_next;
	logic        mism_base;
	logic        mism_next;
	logic [7:0]  size_byte;
	logic        bad;
	logic [1:0]  busy_next;

	assign full = ((pos_q >= POS_DIGEST) && (pos_q < POS_CHECK) && busy_q[bank_q])
		|| ((pos_q == POS_LAST) && vq_full);
	assign accept = push && !full;

	assign p         = frame_start ? 7'd0 : pos_q;
	assign p_off     = p - POS_DIGEST;
	assign in_header = (p < POS_HSIZE);
	assign in_hsize  = (p >= POS_HSIZE) && (p < POS_DIGEST);
	assign in_digest = (p >= POS_DIGEST) && (p < POS_CHECK);
	assign in_check  = (p >= POS_CHECK) && (p < POS_TAIL);
	assign in_tail   = (p >= POS_TAIL);

	assign size_byte = size_cfg[{p[2:0], 3'b000} +: 8];

	always_comb begin
		crc_base  = (p == 7'd0) ? CRC_ONES : crc_q;
		chk_base  = (p == 7'd0) ? 32'd0 : chk_q;
		mism_base = (p == 7'd0) ? 1'b0 : mism_q;
		crc_next  = crc_byte(crc_base, in_check ? 8'd0 : desc_byte);
		chk_next  = chk_base;
		if (in_check) begin
			chk_next = chk_base | ({24'd0, desc_byte} << {p[1:0], 3'b000});
		end
		bad = (in_header && (desc_byte != header_byte(p[4:0])))
			|| (in_hsize && (desc_byte != size_byte))
			|| (in_tail && (desc_byte != 8'd0));
		mism_next = mism_base || bad;
	end

	always_comb begin
		busy_next = busy_q;
		if (vq_push && !vq_din.status) begin
			busy_next[bank_q] = 1'b1;
		end
		if (rel.valid) begin
			busy_next[rel.bank] = 1'b0;
		end
	end

	assign ram_we    = accept && in_digest;
	assign ram_waddr = {bank_q, p_off[IDX_W-1:0]};
	assign ram_wdata = desc_byte;

	assign vq_push       = accept && (p == POS_LAST);
	assign vq_din.status = mism_next || ((crc_next ^ CRC_ONES) != chk_next);
	assign vq_din.bank   = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_ONES;
			chk_q  <= '0;
			mism_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (accept) begin
				pos_q  <= p + 7'd1;
				crc_q  <= crc_next;
				chk_q  <= chk_next;
				mism_q <= mism_next;
			end
			if (vq_push && !vq_din.status) begin
				bank_q <= !bank_q;
			end
			busy_q <= busy_next;
		end
	end

endmodule

FILE: sv/idc_back.sv
// Back end: walks verdicts, reads the digest store and queues result items.
`timescale 1ns / 1ps

module idc_back import idc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vq_empty,
	input  verdict_t         vq_head,
	output logic             vq_pop,
	output logic             ram_re,
	output logic [IDX_W:0]   ram_raddr,
	input  logic [7:0]       ram_rdata,
	output release_t         rel,
	output logic             empty,
	input  logic             pop,
	output logic             status,
	output logic [7:0]       digest_byte,
	output logic [IDX_W-1:0] digest_index,
	output logic             last
);

	typedef struct packed {
		logic             status;
		logic [7:0]       digest_byte;
		logic [IDX_W-1:0] digest_index;
		logic             last;
	} result_t;

	logic [IDX_W-1:0] idx_q;
	logic             valid_s1;
	logic             status_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             last_s1;

	result_t          res_in;
	result_t          res_out;
	logic             of_full;
	logic [1:0]       of_count;
	logic             pop_fire;
	logic [2:0]       pending;
	logic             issue;
	logic             idx_last;

	assign of_count = {of_full, !of_full && !empty};
	assign pop_fire = pop && !empty;
	assign pending  = {1'b0, of_count} + {2'b00, valid_s1} - {2'b00, pop_fire};
	assign issue    = !vq_empty && (pending < 3'd2);
	assign idx_last = (idx_q == IDX_W'(DIGEST_BYTES - 1));

	assign ram_re    = issue && !vq_head.status;
	assign ram_raddr = {vq_head.bank, idx_q};
	assign vq_pop    = issue && (vq_head.status || idx_last);
	assign rel.valid = issue && !vq_head.status && idx_last;
	assign rel.bank  = vq_head.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue && !vq_head.status) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1 <= vq_head.status;
			idx_s1    <= vq_head.status ? '0 : idx_q;
			last_s1   <= vq_head.status || idx_last;
		end
	end

	assign res_in.status       = status_s1;
	assign res_in.digest_byte  = status_s1 ? 8'd0 : ram_rdata;
	assign res_in.digest_index = idx_s1;
	assign res_in.last         = last_s1;

	idc_fifo #(
		.ENTRY_T(result_t),
		.DEPTH  (2)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s1),
		.din   (res_in),
		.full  (of_full),
		.pop   (pop),
		.dout  (res_out),
		.empty (empty)
	);

	assign status       = res_out.status;
	assign digest_byte  = res_out.digest_byte;
	assign digest_index = res_out.digest_index;
	assign last         = res_out.last;

endmodule
